### hw/rtl/accel_tilt_angles_macros.svh
// assertion macros used by the port checker of the tilt angle block
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH

// same-cycle implication, reset masks the check
`define ATILT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tilt angle check failed");

// next-cycle implication, reset masks the check
`define ATILT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tilt angle check failed");

`endif

### hw/rtl/atilt_pkg.sv
// constants, types and tables of the tilt angle block
package atilt_pkg;

    localparam int WIN_LOG2  = 4;
    localparam int WINDOW    = 1 << WIN_LOG2;
    localparam int FILL_W    = $clog2(WINDOW + 2);
    localparam int SUM1_W    = 8 + WIN_LOG2;
    localparam int SUM2_W    = 16 + WIN_LOG2;

    localparam int A_W       = 27;
    localparam int S_W       = 27;
    localparam int Q_W       = 25;
    localparam int DIV_W     = 16;
    localparam int CNT_W     = 5;

    localparam int XY_W      = 45;
    localparam int MAG_W     = 41;
    localparam int Z_W       = 23;
    localparam int ANG_W     = 15;
    localparam int STEPS     = 20;

    localparam logic signed [A_W-1:0] A_SAT = A_W'(1 << 25);
    localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(12868);

    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_ZERO_X   = 3'd0;
    localparam logic [2:0] REG_ONEGEE_X = 3'd1;
    localparam logic [2:0] REG_ZERO_Y   = 3'd2;
    localparam logic [2:0] REG_ONEGEE_Y = 3'd3;
    localparam logic [2:0] REG_ZERO_Z   = 3'd4;
    localparam logic [2:0] REG_ONEGEE_Z = 3'd5;
    localparam logic [2:0] REG_FLOOR    = 3'd6;

    localparam int IN_W   = 24;
    localparam int OUT_W  = 48;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_CAL  = 9'b000000010,
        ST_DIV  = 9'b000000100,
        ST_SUM  = 9'b000001000,
        ST_ANG  = 9'b000010000,
        ST_NORM = 9'b000100000,
        ST_ROT  = 9'b001000000,
        ST_FIN  = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    // arctangent of 2^-i in units of 2^-20 rad
    function automatic logic [19:0] atan_tab(input logic [CNT_W-1:0] i);
        logic [19:0] v;
        unique case (i)
            5'd0:  v = 20'd823550;
            5'd1:  v = 20'd486170;
            5'd2:  v = 20'd256879;
            5'd3:  v = 20'd130396;
            5'd4:  v = 20'd65451;
            5'd5:  v = 20'd32757;
            5'd6:  v = 20'd16383;
            5'd7:  v = 20'd8192;
            5'd8:  v = 20'd4096;
            5'd9:  v = 20'd2048;
            5'd10: v = 20'd1024;
            5'd11: v = 20'd512;
            5'd12: v = 20'd256;
            5'd13: v = 20'd128;
            5'd14: v = 20'd64;
            5'd15: v = 20'd32;
            5'd16: v = 20'd16;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/accel_tilt_angles.sv
// accelerometer tilt angles: averaging, calibration and shared cordic
// Usage of accel_tilt_angles
// s_t* carries one raw sample word (x, y, z counts); m_t* carries one result
// word per sample: roll, pitch, yaw in radians times 8192, and tuser set
// once both averaging stages have warmed up (angles read zero before that).
// The apb port holds the six calibration levels and the denominator floor;
// write them only while the block is idle.
// A sample that is still warming up goes to the done state and then to the
// output register. A warmed-up sample passes each axis through the serial
// divider (a setup step, then one quotient bit a cycle; a zero span skips
// the divider and saturates), then the sum step and, per angle, either a
// saturated store or normalising shifts, 20 rotations and rounding; the
// divider and the cordic rotator are one shared unit each under a
// sequencer.
// s_tready is high only while the sequencer is idle; one sample at a time.
// The result sits in an output register, so the next sample is accepted
// while the last word still waits; a stalled receiver only holds the block
// at the end of the next sample.
// Reset clears the averagers, the fills and the output, and loads the
// default calibration.
module accel_tilt_angles (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [atilt_pkg::IN_W-1:0]      s_tdata,   // accel_x, accel_y, accel_z
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [atilt_pkg::OUT_W-1:0]     m_tdata,   // angle_roll, angle_pitch, angle_yaw, pad
    output logic                            m_tuser,   // angles_valid
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [atilt_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import atilt_pkg::*;

    state_t state_reg;

    logic [8:0]  zero_reg   [3];
    logic [8:0]  onegee_reg [3];
    logic [7:0]  floor_reg;

    logic [SUM1_W-1:0] sum1_reg [3];
    logic [SUM2_W-1:0] sum2_reg [3];
    logic [FILL_W-1:0] fill1_reg, fill2_reg;

    logic signed [A_W-1:0] a_reg [3];
    logic [S_W-1:0]        s_reg;
    logic [1:0]            axis_reg, ang_reg;

    logic [DIV_W-1:0]  rem_reg, dvs_reg;
    logic [Q_W-1:0]    quo_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic signed [XY_W-1:0] x_reg, y_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic signed [Z_W-1:0]  z_reg;

    logic [ANG_W-1:0] res_reg [3];
    logic             resv_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_user_reg;

    // ---------------- averagers
    logic [SUM1_W-1:0] sum1_upd [3];
    logic [SUM2_W-1:0] sum2_upd [3];
    logic [FILL_W-1:0] fill1_upd, fill2_upd;
    logic              v1, v2;
    logic [7:0]        smp [3];

    assign smp[0] = s_tdata[7:0];
    assign smp[1] = s_tdata[15:8];
    assign smp[2] = s_tdata[23:16];

    always_comb
    begin
        fill1_upd = (fill1_reg < FILL_W'(WINDOW + 1)) ? fill1_reg + 1'b1 : fill1_reg;
        fill2_upd = (fill2_reg < FILL_W'(WINDOW + 1)) ? fill2_reg + 1'b1 : fill2_reg;
        v1 = fill1_upd > FILL_W'(WINDOW);
        v2 = v1 && (fill2_upd > FILL_W'(WINDOW));
        for (int i = 0; i < 3; i++)
        begin
            sum1_upd[i] = ((fill1_reg >= FILL_W'(WINDOW)) ?
                           sum1_reg[i] - (sum1_reg[i] >> WIN_LOG2) : sum1_reg[i])
                          + SUM1_W'(smp[i]);
            sum2_upd[i] = ((fill2_reg >= FILL_W'(WINDOW)) ?
                           sum2_reg[i] - (sum2_reg[i] >> WIN_LOG2) : sum2_reg[i])
                          + SUM2_W'({sum1_upd[i][SUM1_W-1:WIN_LOG2], 8'h00});
        end
    end

    // ---------------- calibration for the current axis
    logic signed [17:0] num, span;
    logic [15:0]        num_abs, span_abs;

    always_comb
    begin
        num  = $signed({2'b00, sum2_reg[axis_reg][SUM2_W-1:WIN_LOG2]})
               - $signed({2'b00, zero_reg[axis_reg], 7'b0});
        span = $signed({2'b00, onegee_reg[axis_reg], 7'b0})
               - $signed({2'b00, zero_reg[axis_reg], 7'b0});
        num_abs  = num[17]  ? 16'(-num)  : num[15:0];
        span_abs = span[17] ? 16'(-span) : span[15:0];
    end

    // one restoring divider step
    logic [DIV_W:0]   trial;
    logic             qbit;
    logic [Q_W-1:0]   quo_step;
    logic [DIV_W-1:0] rem_step;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[Q_W-1]};
        qbit     = trial >= {1'b0, dvs_reg};
        rem_step = qbit ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
        quo_step = {quo_reg[Q_W-2:0], qbit};
    end

    // ---------------- angle selection and saturation test
    logic signed [A_W-1:0] an, ad;
    logic [7:0]            lim;
    logic [35:0]           thr, d256, n256;
    logic                  use_atan, n_pos;
    logic [A_W-2:0]        an_abs;

    always_comb
    begin
        unique case (ang_reg)
            2'd0:    begin an = a_reg[1]; ad = a_reg[2]; lim = floor_reg; end
            2'd1:    begin an = a_reg[0]; ad = a_reg[2]; lim = floor_reg; end
            default: begin an = a_reg[0]; ad = a_reg[1]; lim = 8'd0;      end
        endcase
        thr  = 36'({1'b0, lim} + 9'd1) * 36'(s_reg);
        d256 = {2'b00, ad[A_W-2:0], 8'h00};
        n256 = {2'b00, an[A_W-2:0], 8'h00};
        use_atan = (ad > 0) && (d256 >= thr);
        n_pos    = (an > 0) && (n256 >= 36'(s_reg));
        an_abs   = an[A_W-1] ? (A_W-1)'(-an) : an[A_W-2:0];
    end

    // ---------------- cordic rotation and final rounding
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  tab;
    logic signed [Z_W-1:0]  zr;
    logic signed [ANG_W-1:0] zc, sat_ang, store_ang;

    always_comb
    begin
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        tab = $signed(Z_W'(atan_tab(cnt_reg)));
        zr  = (z_reg + Z_W'(64)) >>> 7;
        if (zr > Z_W'(ANG_MAX))
            zc = ANG_MAX;
        else if (zr < -Z_W'(ANG_MAX))
            zc = -ANG_MAX;
        else
            zc = zr[ANG_W-1:0];
        sat_ang   = n_pos ? ANG_MAX : -ANG_MAX;
        store_ang = state_reg == ST_FIN ? zc : sat_ang;
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // ---------------- sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                sum1_reg[i] <= '0;
                sum2_reg[i] <= '0;
                a_reg[i]    <= '0;
                res_reg[i]  <= '0;
            end
            fill1_reg <= '0;
            fill2_reg <= '0;
            s_reg     <= '0;
            axis_reg  <= '0;
            ang_reg   <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            quo_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            mag_reg   <= '0;
            z_reg     <= '0;
            resv_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        fill1_reg <= fill1_upd;
                        for (int i = 0; i < 3; i++)
                            sum1_reg[i] <= sum1_upd[i];
                        if (v1)
                        begin
                            fill2_reg <= fill2_upd;
                            for (int i = 0; i < 3; i++)
                                sum2_reg[i] <= sum2_upd[i];
                        end
                        axis_reg <= '0;
                        resv_reg <= v2;
                        for (int i = 0; i < 3; i++)
                            res_reg[i] <= '0;
                        state_reg <= v2 ? ST_CAL : ST_DONE;
                    end
                end
                ST_CAL:
                begin
                    if (span == '0)
                    begin
                        a_reg[axis_reg] <= (num > 0) ? A_SAT :
                                           ((num < 0) ? -A_SAT : '0);
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= (axis_reg == 2'd2) ? ST_SUM : ST_CAL;
                    end
                    else
                    begin
                        // quotient fits Q_W bits, so the top dividend bits start the remainder
                        rem_reg   <= DIV_W'(num_abs[15:Q_W-16]);
                        quo_reg   <= {num_abs[Q_W-17:0], 16'h0000};
                        dvs_reg   <= span_abs;
                        neg_reg   <= num[17] ^ span[17];
                        cnt_reg   <= CNT_W'(Q_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        a_reg[axis_reg] <= neg_reg ? -A_W'(quo_step) : A_W'(quo_step);
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= (axis_reg == 2'd2) ? ST_SUM : ST_CAL;
                    end
                end
                ST_SUM:
                begin
                    s_reg <= S_W'(a_reg[0][A_W-1] ? -a_reg[0] : a_reg[0])
                           + S_W'(a_reg[1][A_W-1] ? -a_reg[1] : a_reg[1])
                           + S_W'(a_reg[2][A_W-1] ? -a_reg[2] : a_reg[2]);
                    ang_reg   <= '0;
                    state_reg <= ST_ANG;
                end
                ST_ANG:
                begin
                    if (use_atan)
                    begin
                        x_reg   <= XY_W'(ad);
                        y_reg   <= XY_W'(an);
                        mag_reg <= MAG_W'((ad[A_W-2:0] > an_abs) ? ad[A_W-2:0] : an_abs);
                        z_reg   <= '0;
                        state_reg <= ST_NORM;
                    end
                    else
                    begin
                        res_reg[ang_reg] <= (ang_reg == 2'd0) ? store_ang : -store_ang;
                        ang_reg   <= ang_reg + 2'd1;
                        state_reg <= (ang_reg == 2'd2) ? ST_DONE : ST_ANG;
                    end
                end
                ST_NORM:
                begin
                    // bring the larger magnitude up to [2^40, 2^41)
                    if (mag_reg[MAG_W-1:32] == '0)
                    begin
                        mag_reg <= mag_reg << 8;
                        x_reg   <= x_reg <<< 8;
                        y_reg   <= y_reg <<< 8;
                    end
                    else if (!mag_reg[MAG_W-1])
                    begin
                        mag_reg <= mag_reg << 1;
                        x_reg   <= x_reg <<< 1;
                        y_reg   <= y_reg <<< 1;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + tab;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - tab;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEPS - 1))
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    res_reg[ang_reg] <= (ang_reg == 2'd0) ? store_ang : -store_ang;
                    ang_reg   <= ang_reg + 2'd1;
                    state_reg <= (ang_reg == 2'd2) ? ST_DONE : ST_ANG;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= {3'b000, res_reg[2], res_reg[1], res_reg[0]};
                        out_user_reg  <= resv_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- configuration registers
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg[0]   <= 9'd249;
            onegee_reg[0] <= 9'd298;
            zero_reg[1]   <= 9'd248;
            onegee_reg[1] <= 9'd298;
            zero_reg[2]   <= 9'd254;
            onegee_reg[2] <= 9'd304;
            floor_reg     <= 8'd3;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ZERO_X:   zero_reg[0]   <= pwdata[8:0];
                REG_ONEGEE_X: onegee_reg[0] <= pwdata[8:0];
                REG_ZERO_Y:   zero_reg[1]   <= pwdata[8:0];
                REG_ONEGEE_Y: onegee_reg[1] <= pwdata[8:0];
                REG_ZERO_Z:   zero_reg[2]   <= pwdata[8:0];
                REG_ONEGEE_Z: onegee_reg[2] <= pwdata[8:0];
                REG_FLOOR:    floor_reg     <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ZERO_X:   prdata = {23'd0, zero_reg[0]};
            REG_ONEGEE_X: prdata = {23'd0, onegee_reg[0]};
            REG_ZERO_Y:   prdata = {23'd0, zero_reg[1]};
            REG_ONEGEE_Y: prdata = {23'd0, onegee_reg[1]};
            REG_ZERO_Z:   prdata = {23'd0, zero_reg[2]};
            REG_ONEGEE_Z: prdata = {23'd0, onegee_reg[2]};
            REG_FLOOR:    prdata = {24'd0, floor_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### hw/rtl/atilt_checker.sv
// port-level checks of the tilt angle block and their binding
`include "accel_tilt_angles_macros.svh"

module atilt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [atilt_pkg::OUT_W-1:0] m_tdata,
    input logic                        m_tuser
);
    import atilt_pkg::*;

    // angles read zero until the averagers are warm
    `ATILT_ASSERT_IMP(a_cold_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata == '0)

    // every angle lies within a quarter turn
    `ATILT_ASSERT_IMP(a_range, clk, rst_n, m_tvalid && m_tuser,
        $signed(m_tdata[14:0]) >= -ANG_MAX && $signed(m_tdata[14:0]) <= ANG_MAX &&
        $signed(m_tdata[29:15]) >= -ANG_MAX && $signed(m_tdata[29:15]) <= ANG_MAX &&
        $signed(m_tdata[44:30]) >= -ANG_MAX && $signed(m_tdata[44:30]) <= ANG_MAX)

    // one sample at a time: busy right after a word is taken in
    `ATILT_ASSERT_NXT(a_busy, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // a stalled result word holds
    `ATILT_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind accel_tilt_angles atilt_checker u_atilt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/accel_tilt_angles_checker.sv
// result checker of the tilt angle block: predicts each word and compares it
module accel_tilt_angles_checker
    import atilt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // accel_x, accel_y, accel_z
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,   // angle_roll, angle_pitch, angle_yaw, pad
    input  logic                 m_tuser,   // angles_valid
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        logic                    valid;
    } angles_t;

    localparam longint ANG_LIM = 12868;

    logic [31:0] stage1_sum [3];
    logic [31:0] stage2_sum [3];
    int          stage1_fill;
    int          stage2_fill;
    logic [8:0]  zero_lvl [3];
    logic [8:0]  onegee_lvl [3];
    logic [7:0]  den_floor;
    angles_t     expected_angles [$];

    function automatic longint cordic_angle(longint n, longint d);
        longint x, y, z, mag, xs, ys;
        x = d;
        y = n;
        z = 0;
        mag = (n < 0) ? -n : n;
        if (d > mag)
            mag = d;
        while (mag < (64'sd1 <<< 40))
        begin
            mag = mag * 2;
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_tab(CNT_W'(i)));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_tab(CNT_W'(i)));
            end
        end
        z = (z + 64) >>> 7;
        if (z > ANG_LIM)
            z = ANG_LIM;
        if (z < -ANG_LIM)
            z = -ANG_LIM;
        return z;
    endfunction

    function automatic longint tilt_of(longint tn, longint td, longint an, longint ad,
                                       longint lim);
        if (td > lim)
            return cordic_angle(an, ad);
        return (tn > 0) ? ANG_LIM : -ANG_LIM;
    endfunction

    function automatic angles_t next_angles(logic [7:0] raw [3]);
        angles_t r;
        longint  a [3];
        longint  t [3];
        longint  s, num, span;
        r = '0;
        s = 0;
        if (stage1_fill >= WINDOW)
            for (int i = 0; i < 3; i++)
                stage1_sum[i] = stage1_sum[i] - stage1_sum[i] / WINDOW;
        if (stage1_fill < WINDOW + 1)
            stage1_fill++;
        for (int i = 0; i < 3; i++)
            stage1_sum[i] = stage1_sum[i] + 32'(raw[i]);
        if (stage1_fill <= WINDOW)
            return r;
        if (stage2_fill >= WINDOW)
            for (int i = 0; i < 3; i++)
                stage2_sum[i] = stage2_sum[i] - stage2_sum[i] / WINDOW;
        if (stage2_fill < WINDOW + 1)
            stage2_fill++;
        for (int i = 0; i < 3; i++)
            stage2_sum[i] = stage2_sum[i] + ((stage1_sum[i] / WINDOW) << 8);
        if (stage2_fill <= WINDOW)
            return r;
        for (int i = 0; i < 3; i++)
        begin
            num = longint'(stage2_sum[i] / WINDOW) - longint'(zero_lvl[i]) * 128;
            span = (longint'(onegee_lvl[i]) - longint'(zero_lvl[i])) * 128;
            if (span == 0)
                a[i] = (num > 0) ? (64'sd1 <<< 25) : ((num < 0) ? -(64'sd1 <<< 25) : 0);
            else
                a[i] = (num * 65536) / span;
            s += (a[i] < 0) ? -a[i] : a[i];
        end
        for (int i = 0; i < 3; i++)
            t[i] = (s != 0) ? (a[i] * 256) / s : 0;
        r.roll  = ANG_W'(tilt_of(t[1], t[2], a[1], a[2], longint'(den_floor)));
        r.pitch = ANG_W'(-tilt_of(t[0], t[2], a[0], a[2], longint'(den_floor)));
        r.yaw   = ANG_W'(-tilt_of(t[0], t[1], a[0], a[1], 0));
        r.valid = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        angles_t     got;
        angles_t     want;
        logic [7:0]  raw [3];
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                stage1_sum[i] = '0;
                stage2_sum[i] = '0;
            end
            stage1_fill = 0;
            stage2_fill = 0;
            zero_lvl[0] = 9'd249; onegee_lvl[0] = 9'd298;
            zero_lvl[1] = 9'd248; onegee_lvl[1] = 9'd298;
            zero_lvl[2] = 9'd254; onegee_lvl[2] = 9'd304;
            den_floor = 8'd3;
            expected_angles.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_ZERO_X:   zero_lvl[0]   = pwdata[8:0];
                    REG_ONEGEE_X: onegee_lvl[0] = pwdata[8:0];
                    REG_ZERO_Y:   zero_lvl[1]   = pwdata[8:0];
                    REG_ONEGEE_Y: onegee_lvl[1] = pwdata[8:0];
                    REG_ZERO_Z:   zero_lvl[2]   = pwdata[8:0];
                    REG_ONEGEE_Z: onegee_lvl[2] = pwdata[8:0];
                    REG_FLOOR:    den_floor     = pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                raw[0] = s_tdata[7:0];
                raw[1] = s_tdata[15:8];
                raw[2] = s_tdata[23:16];
                expected_angles.push_back(next_angles(raw));
            end
            if (m_tvalid && m_tready)
            begin
                got.roll  = m_tdata[14:0];
                got.pitch = m_tdata[29:15];
                got.yaw   = m_tdata[44:30];
                got.valid = m_tuser;
                if (expected_angles.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word roll %0d pitch %0d yaw %0d valid %0b",
                             $time, got.roll, got.pitch, got.yaw, got.valid);
                end
                else
                begin
                    want = expected_angles.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected roll %0d pitch %0d yaw %0d valid %0b",
                                 $time, want.roll, want.pitch, want.yaw, want.valid);
                        $display("%0t:          actual   roll %0d pitch %0d yaw %0d valid %0b",
                                 $time, got.roll, got.pitch, got.yaw, got.valid);
                    end
                end
            end
            pending = expected_angles.size();
        end
    end

endmodule

### bench/accel_tilt_angles_tb.sv
// testbench top of the tilt angle block: stimulus, calibration writes, verdict
module accel_tilt_angles_tb;
    import atilt_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SINK_HOLD   = 3000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  cycles;
    logic                steady;
    logic                hold_req;
    logic                hold_done;
    int                  hold_left;
    int                  tx, ty, tz;

    accel_tilt_angles i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    accel_tilt_angles_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold so the block backs up
    always @(posedge clk)
    begin
        if (hold_req && !hold_done && hold_left == 0)
        begin
            hold_left = SINK_HOLD;
            hold_done <= 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= 8);
    end

    task automatic reg_write(logic [2:0] idx, int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_sink();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic load_calibration(int unsigned zx, int unsigned gx, int unsigned zy,
                                    int unsigned gy, int unsigned zz, int unsigned gz,
                                    int unsigned fl);
        drain_sink();
        reg_write(REG_ZERO_X, zx);
        reg_write(REG_ONEGEE_X, gx);
        reg_write(REG_ZERO_Y, zy);
        reg_write(REG_ONEGEE_Y, gy);
        reg_write(REG_ZERO_Z, zz);
        reg_write(REG_ONEGEE_Z, gz);
        reg_write(REG_FLOOR, fl);
    endtask

    task automatic send_sample(logic [7:0] x, logic [7:0] y, logic [7:0] z);
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!steady && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] near(int centre);
        int v;
        v = centre + $urandom_range(16) - 8;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // random orientation held for runs of 40 samples, with sensor noise and some fully random words
    task automatic send_motion(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                tx = $urandom_range(255);
                ty = $urandom_range(255);
                tz = $urandom_range(255);
            end
            if ($urandom_range(9) == 0)
                send_sample(8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_sample(near(tx), near(ty), near(tz));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // warm-up words with field extremes, samples sitting at the zero levels, then runs at the extremes
        send_sample(8'd0, 8'd0, 8'd0);
        send_sample(8'd255, 8'd255, 8'd255);
        send_sample(8'hAA, 8'h55, 8'hF0);
        send_sample(8'h55, 8'hAA, 8'h0F);
        for (int n = 0; n < 40; n++)
            send_sample(8'd124, 8'd124, 8'd127);
        for (int n = 0; n < 20; n++)
            send_sample(8'd255, 8'd0, 8'd255);
        for (int n = 0; n < 20; n++)
            send_sample(8'd0, 8'd255, 8'd0);

        // widest spans, highest floor
        load_calibration(0, 511, 0, 511, 0, 511, 255);
        send_motion(200);

        // zero spans on every axis, floor at zero; sender then waits for all words
        load_calibration(250, 250, 0, 0, 511, 511, 0);
        for (int n = 0; n < 40; n++)
            send_sample(8'd125, 8'd0, 8'd255);
        send_motion(120);

        // inverted spans on x and y, with a long receiver hold while samples keep coming
        load_calibration(511, 0, 300, 200, 200, 300, 1);
        hold_req <= 1'b1;
        send_motion(150);

        // quiet stretch with no idling on either side
        load_calibration(249, 298, 248, 298, 254, 304, 3);
        steady <= 1'b1;
        send_motion(150);
        steady <= 1'b0;

        for (int p = 0; p < 4; p++)
        begin
            load_calibration($urandom_range(511), $urandom_range(511),
                             $urandom_range(511), $urandom_range(511),
                             $urandom_range(511), $urandom_range(511),
                             (p == 0) ? 0 : $urandom_range(255));
            send_motion(125);
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
